### sv/m4ae_pkg.sv
// Shared types, constants and helpers of the 4x4 matrix arithmetic engine.
package m4ae_pkg;

    localparam int DIM        = 4;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int REQ_W      = 3;
    localparam int PORT_IDX_W = 2;
    localparam int NELEM      = DIM * DIM;
    localparam int IDX_W      = $clog2(DIM);
    localparam int ADDR_W     = $clog2(NELEM);
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = PROD_W + $clog2(DIM);
    localparam int DRAIN_CYC  = 4;
    localparam int CNT_W      = $clog2(DRAIN_CYC);

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_WR_A   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WR_B   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WR_C   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ADD    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SUB    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_MUL    = 3'd5;
    localparam logic [REQ_W-1:0] REQ_TRANSP = 3'd6;
    localparam logic [REQ_W-1:0] REQ_TRIPLE = 3'd7;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MAC,
        OP_PASS
    } op_t;

    typedef enum logic [1:0] {
        DST_OUT,
        DST_TMP,
        DST_OUT_A
    } dest_t;

    // One datapath step, issued by the controller each cycle while it runs an operation.
    typedef struct packed {
        logic              valid;
        op_t               op;
        logic              lsel_tmp;
        logic              rsel_c;
        logic [ADDR_W-1:0] addr_l;
        logic [ADDR_W-1:0] addr_r;
        logic              first;
        logic              fin;
        logic [IDX_W-1:0]  oi;
        logic [IDX_W-1:0]  oj;
        dest_t             dest;
    } cmd_t;

    // Element load strobes for a write request.
    typedef struct packed {
        logic a;
        logic b;
        logic c;
    } ld_t;

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
        elem_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(DIM) + ADDR_W'(c));
    endfunction

endpackage

### sv/m4ae_ram.sv
// Generic single-write, single-read RAM with registered read data.
module m4ae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/m4ae_ctrl.sv
// Controller: sequences the element, inner-product and pass steps of each operation.
module m4ae_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [m4ae_pkg::REQ_W-1:0]     req_type,
    output logic                           busy,
    output m4ae_pkg::ld_t                  ld,
    output m4ae_pkg::cmd_t                 cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t                          state_reg, state_next;
    logic [m4ae_pkg::REQ_W-1:0]      op_reg, op_next;
    logic                            phase_reg, phase_next;
    logic [m4ae_pkg::IDX_W-1:0]      i_reg, i_next;
    logic [m4ae_pkg::IDX_W-1:0]      j_reg, j_next;
    logic [m4ae_pkg::IDX_W-1:0]      k_reg, k_next;
    logic [m4ae_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    m4ae_pkg::cmd_t                  cmd_reg, cmd_next, step;
    logic                            accept;
    logic                            is_mac;
    logic                            k_last;
    logic                            j_last;
    logic                            i_last;

    localparam logic [m4ae_pkg::IDX_W-1:0] IDX_LAST = m4ae_pkg::IDX_W'(m4ae_pkg::DIM - 1);

    assign accept = start && !busy_reg;
    assign is_mac = (op_reg == m4ae_pkg::REQ_MUL) || (op_reg == m4ae_pkg::REQ_TRIPLE);
    assign k_last = !is_mac || (k_reg == IDX_LAST);
    assign j_last = (j_reg == IDX_LAST);
    assign i_last = (i_reg == IDX_LAST);

    // Load strobes are decoded straight from the request so a write lands on its accept edge.
    always_comb
    begin
        ld = '0;
        if (accept)
        begin
            unique case (req_type)
                m4ae_pkg::REQ_WR_A: ld.a = 1'b1;
                m4ae_pkg::REQ_WR_B: ld.b = 1'b1;
                m4ae_pkg::REQ_WR_C: ld.c = 1'b1;
                default:            ld   = '0;
            endcase
        end
    end

    // Step built from the loop counters.
    always_comb
    begin
        step          = '0;
        step.valid    = 1'b1;
        step.oi       = i_reg;
        step.oj       = j_reg;
        step.first    = 1'b1;
        step.fin      = 1'b1;
        step.addr_l   = m4ae_pkg::elem_addr(i_reg, j_reg);
        step.addr_r   = m4ae_pkg::elem_addr(i_reg, j_reg);
        step.op       = m4ae_pkg::OP_ADD;
        step.dest     = m4ae_pkg::DST_OUT;
        unique case (op_reg) inside
            m4ae_pkg::REQ_SUB:
            begin
                step.op = m4ae_pkg::OP_SUB;
            end
            m4ae_pkg::REQ_MUL, m4ae_pkg::REQ_TRIPLE:
            begin
                step.op       = m4ae_pkg::OP_MAC;
                step.addr_l   = m4ae_pkg::elem_addr(i_reg, k_reg);
                step.addr_r   = m4ae_pkg::elem_addr(k_reg, j_reg);
                step.first    = (k_reg == '0);
                step.fin      = (k_reg == IDX_LAST);
                if (op_reg == m4ae_pkg::REQ_TRIPLE)
                begin
                    step.lsel_tmp = phase_reg;
                    step.rsel_c   = phase_reg;
                    step.dest     = phase_reg ? m4ae_pkg::DST_OUT : m4ae_pkg::DST_TMP;
                end
            end
            m4ae_pkg::REQ_TRANSP:
            begin
                step.op       = m4ae_pkg::OP_PASS;
                step.lsel_tmp = phase_reg;
                step.dest     = phase_reg ? m4ae_pkg::DST_OUT_A : m4ae_pkg::DST_TMP;
                if (!phase_reg)
                begin
                    step.addr_l = m4ae_pkg::elem_addr(j_reg, i_reg);
                end
            end
            default:
            begin
                step.op = m4ae_pkg::OP_ADD;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        phase_next = phase_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        cmd_next   = step;
        cmd_next.valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type >= m4ae_pkg::REQ_ADD))
                begin
                    op_next    = req_type;
                    phase_next = 1'b0;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd_next = step;
                if (!k_last)
                begin
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    k_next = '0;
                    if (!j_last)
                    begin
                        j_next = j_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = '0;
                        if (!i_last)
                        begin
                            i_next = i_reg + 1'b1;
                        end
                        else
                        begin
                            i_next     = '0;
                            cnt_next   = m4ae_pkg::CNT_W'(m4ae_pkg::DRAIN_CYC - 1);
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    if (!phase_reg && ((op_reg == m4ae_pkg::REQ_TRIPLE) ||
                                       (op_reg == m4ae_pkg::REQ_TRANSP)))
                    begin
                        phase_next = 1'b1;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            busy_reg      <= 1'b0;
            cmd_reg.valid <= 1'b0;
            phase_reg     <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            op_reg        <= m4ae_pkg::REQ_ADD;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
            op_reg    <= op_next;
        end
    end

    assign busy = busy_reg;
    assign cmd  = cmd_reg;

    a_idle_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !cmd_reg.valid)
        else $error("datapath step issued while idle");

    a_op_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type >= m4ae_pkg::REQ_ADD)) |=> busy)
        else $error("operation request did not raise busy");

    a_single_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_reg.valid && (cmd_reg.op != m4ae_pkg::OP_MAC)) |-> (cmd_reg.first && cmd_reg.fin))
        else $error("element step not marked as first and final");

endmodule

### sv/m4ae_dpath.sv
// Datapath: matrix stores, multiplier, accumulator, saturation and result register.
module m4ae_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  m4ae_pkg::ld_t                       ld,
    input  m4ae_pkg::cmd_t                      cmd,
    input  logic [m4ae_pkg::PORT_IDX_W-1:0]     row,
    input  logic [m4ae_pkg::PORT_IDX_W-1:0]     col,
    input  logic signed [m4ae_pkg::DATA_W-1:0]  value,
    output logic                                out_valid,
    output logic [m4ae_pkg::PORT_IDX_W-1:0]     out_row,
    output logic [m4ae_pkg::PORT_IDX_W-1:0]     out_col,
    output logic signed [m4ae_pkg::DATA_W-1:0]  out_value,
    output logic                                last
);

    localparam logic [m4ae_pkg::IDX_W-1:0] IDX_LAST = m4ae_pkg::IDX_W'(m4ae_pkg::DIM - 1);

    m4ae_pkg::cmd_t                          cmd1_reg, cmd2_reg, cmd3_reg;
    logic signed [m4ae_pkg::PROD_W-1:0]      p2_reg, p2_next;
    logic signed [m4ae_pkg::ACC_W-1:0]       acc_reg, acc_next;
    logic signed [m4ae_pkg::ACC_W-1:0]       scaled;
    logic signed [m4ae_pkg::DATA_W-1:0]      res;
    logic signed [m4ae_pkg::DATA_W-1:0]      a_rd, b_rd, c_rd, t_rd;
    logic signed [m4ae_pkg::DATA_W-1:0]      l_op, r_op;
    logic                                    in_range;
    logic [m4ae_pkg::ADDR_W-1:0]             ld_addr;
    logic [m4ae_pkg::ADDR_W-1:0]             res_addr;
    logic                                    res_we;
    logic                                    a_we, t_we;
    logic [m4ae_pkg::ADDR_W-1:0]             a_waddr;
    logic signed [m4ae_pkg::DATA_W-1:0]      a_wdata;
    logic                                    out_valid_reg;
    logic [m4ae_pkg::PORT_IDX_W-1:0]         out_row_reg, out_col_reg;
    logic signed [m4ae_pkg::DATA_W-1:0]      out_value_reg;
    logic                                    last_reg;

    // Writes whose row or column lies outside the matrix are dropped.
    assign in_range = (int'(row) < m4ae_pkg::DIM) && (int'(col) < m4ae_pkg::DIM);
    assign ld_addr  = m4ae_pkg::elem_addr(m4ae_pkg::IDX_W'(row), m4ae_pkg::IDX_W'(col));
    assign res_addr = m4ae_pkg::elem_addr(cmd3_reg.oi, cmd3_reg.oj);
    assign res_we   = cmd3_reg.valid && cmd3_reg.fin;

    assign a_we    = (ld.a && in_range) || (res_we && (cmd3_reg.dest == m4ae_pkg::DST_OUT_A));
    assign a_waddr = ld.a ? ld_addr : res_addr;
    assign a_wdata = ld.a ? value : res;
    assign t_we    = res_we && (cmd3_reg.dest == m4ae_pkg::DST_TMP);

    m4ae_ram #(.WIDTH(m4ae_pkg::DATA_W), .DEPTH(m4ae_pkg::NELEM)) u_ram_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (cmd.addr_l),
        .rdata (a_rd)
    );

    m4ae_ram #(.WIDTH(m4ae_pkg::DATA_W), .DEPTH(m4ae_pkg::NELEM)) u_ram_b (
        .clk   (clk),
        .we    (ld.b && in_range),
        .waddr (ld_addr),
        .wdata (value),
        .raddr (cmd.addr_r),
        .rdata (b_rd)
    );

    m4ae_ram #(.WIDTH(m4ae_pkg::DATA_W), .DEPTH(m4ae_pkg::NELEM)) u_ram_c (
        .clk   (clk),
        .we    (ld.c && in_range),
        .waddr (ld_addr),
        .wdata (value),
        .raddr (cmd.addr_r),
        .rdata (c_rd)
    );

    m4ae_ram #(.WIDTH(m4ae_pkg::DATA_W), .DEPTH(m4ae_pkg::NELEM)) u_ram_t (
        .clk   (clk),
        .we    (t_we),
        .waddr (res_addr),
        .wdata (res),
        .raddr (cmd.addr_l),
        .rdata (t_rd)
    );

    assign l_op = cmd1_reg.lsel_tmp ? t_rd : a_rd;
    assign r_op = cmd1_reg.rsel_c ? c_rd : b_rd;

    always_comb
    begin
        case (cmd1_reg.op)
            m4ae_pkg::OP_ADD:  p2_next = m4ae_pkg::PROD_W'(l_op) + m4ae_pkg::PROD_W'(r_op);
            m4ae_pkg::OP_SUB:  p2_next = m4ae_pkg::PROD_W'(l_op) - m4ae_pkg::PROD_W'(r_op);
            m4ae_pkg::OP_MAC:  p2_next = l_op * r_op;
            default:           p2_next = m4ae_pkg::PROD_W'(l_op);
        endcase
    end

    // Exact accumulation; the floor shift is applied once on the full sum.
    assign acc_next = (cmd2_reg.first ? '0 : acc_reg) + m4ae_pkg::ACC_W'(p2_reg);

    always_comb
    begin
        if (cmd3_reg.op == m4ae_pkg::OP_MAC)
        begin
            scaled = acc_reg >>> m4ae_pkg::FRAC_BITS;
        end
        else
        begin
            scaled = acc_reg;
        end
        if (scaled > m4ae_pkg::ACC_W'(m4ae_pkg::SAT_MAX))
        begin
            res = m4ae_pkg::SAT_MAX;
        end
        else if (scaled < m4ae_pkg::ACC_W'(m4ae_pkg::SAT_MIN))
        begin
            res = m4ae_pkg::SAT_MIN;
        end
        else
        begin
            res = m4ae_pkg::DATA_W'(scaled);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd1_reg.valid <= 1'b0;
            cmd2_reg.valid <= 1'b0;
            cmd3_reg.valid <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cmd1_reg      <= cmd;
            cmd2_reg      <= cmd1_reg;
            cmd3_reg      <= cmd2_reg;
            out_valid_reg <= res_we && (cmd3_reg.dest != m4ae_pkg::DST_TMP);
        end
    end

    always_ff @(posedge clk)
    begin
        p2_reg        <= p2_next;
        acc_reg       <= acc_next;
        out_row_reg   <= m4ae_pkg::PORT_IDX_W'(cmd3_reg.oi);
        out_col_reg   <= m4ae_pkg::PORT_IDX_W'(cmd3_reg.oj);
        out_value_reg <= res;
        last_reg      <= (cmd3_reg.oi == IDX_LAST) && (cmd3_reg.oj == IDX_LAST);
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign last      = last_reg;

    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> ((out_row == m4ae_pkg::PORT_IDX_W'(m4ae_pkg::DIM - 1)) &&
                                 (out_col == m4ae_pkg::PORT_IDX_W'(m4ae_pkg::DIM - 1))))
        else $error("last flag away from the final element");

    a_no_a_collide: assert property (@(posedge clk) disable iff (!rst_n)
        !(ld.a && res_we && (cmd3_reg.dest == m4ae_pkg::DST_OUT_A)))
        else $error("element load collides with transpose write-back");

endmodule

### sv/matrix4x4_arith_engine.sv
// Top level of the 4x4 fixed-point matrix arithmetic engine.
//
// Usage: a request is taken at a rising edge where start is high and busy is low.
// req_type selects a load of one element of A, B or C (row, col, value) or an
// operation on the stored matrices: A+B, A-B, A*B, transpose of A (written back
// into A) or (A*B)*C. Elements are signed Q16.16; sums saturate to 32 bits and
// products are kept exact, floored by 16 fraction bits and then saturated.
// A load completes on its accept edge and never raises busy, so loads may come
// back to back. An operation produces sixteen results in row-major order; each
// is shown for exactly one cycle with out_valid high, and last marks the final one.
// Add and subtract produce their results at one per cycle. Multiply runs one
// multiply-accumulate per cycle through a single 32x32 multiplier, summing the
// four products of each result in turn. The triple product and the transpose
// each run two passes through a scratch matrix; results come only in the
// second pass. The receiver cannot hold results off; they leave as produced.
// Reset clears the controller and pipeline valid bits; matrix contents are not
// cleared and must be loaded before an operation reads them.
module matrix4x4_arith_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [m4ae_pkg::REQ_W-1:0]          req_type,
    input  logic [m4ae_pkg::PORT_IDX_W-1:0]     row,
    input  logic [m4ae_pkg::PORT_IDX_W-1:0]     col,
    input  logic signed [m4ae_pkg::DATA_W-1:0]  value,
    output logic                                out_valid,
    output logic [m4ae_pkg::PORT_IDX_W-1:0]     out_row,
    output logic [m4ae_pkg::PORT_IDX_W-1:0]     out_col,
    output logic signed [m4ae_pkg::DATA_W-1:0]  out_value,
    output logic                                last
);

    // Command path from the sequencer: per-cycle step and element load strobes.
    m4ae_pkg::cmd_t cmd;
    m4ae_pkg::ld_t  ld;

    m4ae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .busy     (busy),
        .ld       (ld),
        .cmd      (cmd)
    );

    // The datapath holds the matrices and computes one step per cycle.
    m4ae_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ld        (ld),
        .cmd       (cmd),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .last      (last)
    );

endmodule
